// ===== rtl/core/cfpg_pkg.sv =====
package cfpg_pkg;

	// grid size used by the position offsets
	localparam int GRID_WIDTH  = 6;
	localparam int GRID_HEIGHT = 6;

	// cycles from an accepted start to the result strobe
	localparam int PIPE_LATENCY = 7;

	// phase steps per frame, 16-bit turn fractions
	localparam logic [15:0] FRAME_STEP_F = 16'd8344;
	localparam logic [15:0] FRAME_STEP_R = 16'd2086;
	localparam logic [15:0] FRAME_STEP_G = 16'd1565;

	// Q14 constants
	localparam logic signed [16:0] FLICK_BIAS = 17'sd11469;
	localparam logic signed [14:0] FLICK_AMP  = 15'sd4915;
	localparam logic signed [16:0] WIND_BIAS  = 17'sd16384;
	localparam logic [12:0]        WIND_AMP_R = 13'd4915;
	localparam logic [12:0]        WIND_AMP_G = 13'd3277;
	localparam logic [14:0]        SINE_PEAK  = 15'd16384;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic [2:0] {
		REG_BASE_RED     = 3'd0,
		REG_BASE_GREEN   = 3'd1,
		REG_BASE_BLUE    = 3'd2,
		REG_FLICKER_GAIN = 3'd3,
		REG_WIND_GAIN    = 3'd4
	} cfg_reg_e;

	localparam logic [7:0] RST_BASE_RED     = 8'd255;
	localparam logic [7:0] RST_BASE_GREEN   = 8'd100;
	localparam logic [7:0] RST_BASE_BLUE    = 8'd20;
	localparam logic [9:0] RST_FLICKER_GAIN = 10'd256;
	localparam logic [8:0] RST_WIND_GAIN    = 9'd128;

	typedef struct packed {
		logic [15:0] frame_index;
		logic [2:0]  column;
		logic [2:0]  row;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	// register contents plus the wind coefficients premultiplied at write time
	typedef struct packed {
		logic [7:0]  base_red;
		logic [7:0]  base_green;
		logic [7:0]  base_blue;
		logic [9:0]  flicker_gain;
		logic [21:0] coef_r;
		logic [21:0] coef_g;
	} cfg_t;

	typedef struct packed {
		logic [15:0]        ang_f;
		logic [15:0]        ang_r;
		logic [15:0]        ang_g;
		logic signed [15:0] shape;
	} s1_t;

	typedef logic [15:0]        off_tab_t [8];
	typedef logic signed [15:0] shape_tab_t [8];
	typedef logic [14:0]        qsine_tab_t [256];

	function automatic off_tab_t col_offsets(logic [31:0] mult);
		off_tab_t tab;
		for (int c = 0; c < 8; c++) begin
			tab[c] = 16'((32'(c) * mult) / (GRID_WIDTH - 1));
		end
		return tab;
	endfunction

	function automatic off_tab_t row_offsets(logic [31:0] mult);
		off_tab_t tab;
		for (int r = 0; r < 8; r++) begin
			tab[r] = 16'((32'(r) * mult) / (GRID_HEIGHT - 1));
		end
		return tab;
	endfunction

	function automatic shape_tab_t shape_rows();
		shape_tab_t tab;
		for (int r = 0; r < 8; r++) begin
			tab[r] = 16'(16384 - (r * 13107) / (GRID_HEIGHT - 1));
		end
		return tab;
	endfunction

	// first quadrant of sine, Q1.14, Taylor series in Q30
	function automatic logic [14:0] quarter_sine(int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x  = (64'(k) * PI_Q30 + 64'd256) >> 9;
		x2 = (x * x) >> 30;
		t  = x;
		s  = x;
		t  = ((t * x2) >> 30) / 64'd6;   s = s - t;
		t  = ((t * x2) >> 30) / 64'd20;  s = s + t;
		t  = ((t * x2) >> 30) / 64'd42;  s = s - t;
		t  = ((t * x2) >> 30) / 64'd72;  s = s + t;
		t  = ((t * x2) >> 30) / 64'd110; s = s - t;
		t  = ((t * x2) >> 30) / 64'd156; s = s + t;
		t  = ((t * x2) >> 30) / 64'd210; s = s - t;
		return 15'((s + 64'd32768) >> 16);
	endfunction

	function automatic qsine_tab_t build_qsine();
		qsine_tab_t tab;
		for (int unsigned k = 0; k < 256; k++) begin
			tab[k] = quarter_sine(k);
		end
		return tab;
	endfunction

	localparam off_tab_t   COL_OFF_F = col_offsets(32'd52152);
	localparam off_tab_t   COL_OFF_G = col_offsets(32'd20861);
	localparam off_tab_t   ROW_OFF_R = row_offsets(32'd31291);
	localparam shape_tab_t SHAPE_TAB = shape_rows();
	localparam qsine_tab_t QSINE_TAB = build_qsine();

endpackage

// ===== rtl/core/cfpg_cfg_regs.sv =====
module cfpg_cfg_regs
	import cfpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_red     <= RST_BASE_RED;
			cfg_q.base_green   <= RST_BASE_GREEN;
			cfg_q.base_blue    <= RST_BASE_BLUE;
			cfg_q.flicker_gain <= RST_FLICKER_GAIN;
			cfg_q.coef_r       <= {9'd0, WIND_AMP_R} * {13'd0, RST_WIND_GAIN};
			cfg_q.coef_g       <= {9'd0, WIND_AMP_G} * {13'd0, RST_WIND_GAIN};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_RED:     cfg_q.base_red     <= cfg_data[7:0];
				REG_BASE_GREEN:   cfg_q.base_green   <= cfg_data[7:0];
				REG_BASE_BLUE:    cfg_q.base_blue    <= cfg_data[7:0];
				REG_FLICKER_GAIN: cfg_q.flicker_gain <= cfg_data;
				REG_WIND_GAIN: begin
					// wind gain kept only as its two premultiplied coefficients
					cfg_q.coef_r <= {9'd0, WIND_AMP_R} * {13'd0, cfg_data[8:0]};
					cfg_q.coef_g <= {9'd0, WIND_AMP_G} * {13'd0, cfg_data[8:0]};
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/cfpg_front.sv =====
module cfpg_front
	import cfpg_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   take,
	input  pixel_t pixel,
	output logic   v_s1,
	output s1_t    d_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	// phases wrap modulo one turn
	always_ff @(posedge clk) begin
		d_s1.ang_f <= 16'(pixel.frame_index * FRAME_STEP_F) + COL_OFF_F[pixel.column];
		d_s1.ang_r <= 16'(pixel.frame_index * FRAME_STEP_R) + ROW_OFF_R[pixel.row];
		d_s1.ang_g <= 16'(pixel.frame_index * FRAME_STEP_G) + COL_OFF_G[pixel.column];
		d_s1.shape <= SHAPE_TAB[pixel.row];
	end

endmodule

// ===== rtl/core/cfpg_sine_lut.sv =====
module cfpg_sine_lut
	import cfpg_pkg::*;
(
	input  logic               clk,
	input  logic [15:0]        angle,
	output logic signed [15:0] sine
);

	logic        mirror;
	logic [7:0]  k;
	logic [7:0]  qi;
	logic [14:0] mag;

	// quarter-wave table, second and fourth quadrants read backwards
	assign mirror = angle[14];
	assign k      = angle[13:6];
	assign qi     = mirror ? 8'(8'd0 - k) : k;
	assign mag    = (mirror && k == 8'd0) ? SINE_PEAK : QSINE_TAB[qi];

	always_ff @(posedge clk) begin
		if (angle[15]) begin
			sine <= -$signed({1'b0, mag});
		end else begin
			sine <= $signed({1'b0, mag});
		end
	end

endmodule

// ===== rtl/core/cfpg_back.sv =====
module cfpg_back
	import cfpg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               v_s2,
	input  logic signed [15:0] shape_s2,
	input  logic signed [15:0] sin_f,
	input  logic signed [15:0] sin_r,
	input  logic signed [15:0] sin_g,
	input  cfg_t               cfg,
	output logic               done,
	output color_t             color
);

	logic               v_s3, v_s4, v_s5, v_s6;
	logic signed [15:0] shape_s3, shape_s4;
	logic signed [30:0] fprod_s3;
	logic signed [38:0] rprod_s3, gprod_s3;

	logic signed [16:0] flick0;
	logic signed [16:0] windr_w, windg_w;
	logic [24:0]        fscaled;
	logic [15:0]        flick_s4;
	logic [14:0]        windr_s4, windg_s4;

	logic signed [32:0] common_s5;
	logic [22:0]        redf_s5, grnf_s5;

	logic signed [56:0] pr_s6, pg_s6;
	logic signed [41:0] pb_s6;

	logic [7:0] red_w, green_w, blue_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			done <= v_s6;
		end
	end

	// s3: sine products
	always_ff @(posedge clk) begin
		shape_s3 <= shape_s2;
		fprod_s3 <= FLICK_AMP * sin_f;
		rprod_s3 <= $signed({1'b0, cfg.coef_r}) * sin_r;
		gprod_s3 <= $signed({1'b0, cfg.coef_g}) * sin_g;
	end

	// s4: flicker level and wind factors, all positive here
	assign flick0  = FLICK_BIAS + 17'(fprod_s3 >>> 14);
	assign fscaled = flick0[14:0] * cfg.flicker_gain;
	assign windr_w = WIND_BIAS + 17'(rprod_s3 >>> 22);
	assign windg_w = WIND_BIAS + 17'(gprod_s3 >>> 22);

	always_ff @(posedge clk) begin
		shape_s4 <= shape_s3;
		flick_s4 <= fscaled[23:8];
		windr_s4 <= windr_w[14:0];
		windg_s4 <= windg_w[14:0];
	end

	// s5: shape times flicker, base levels times wind
	always_ff @(posedge clk) begin
		common_s5 <= shape_s4 * $signed({1'b0, flick_s4});
		redf_s5   <= cfg.base_red * windr_s4;
		grnf_s5   <= cfg.base_green * windg_s4;
	end

	// s6: full channel products
	always_ff @(posedge clk) begin
		pr_s6 <= common_s5 * $signed({1'b0, redf_s5});
		pg_s6 <= common_s5 * $signed({1'b0, grnf_s5});
		pb_s6 <= common_s5 * $signed({1'b0, cfg.base_blue});
	end

	// s7: floor, zero for non-positive, saturate
	always_comb begin
		if (pr_s6 <= 0) begin
			red_w = 8'd0;
		end else if (|pr_s6[56:50]) begin
			red_w = 8'hff;
		end else begin
			red_w = pr_s6[49:42];
		end
		if (pg_s6 <= 0) begin
			green_w = 8'd0;
		end else if (|pg_s6[56:50]) begin
			green_w = 8'hff;
		end else begin
			green_w = pg_s6[49:42];
		end
		if (pb_s6 <= 0) begin
			blue_w = 8'd0;
		end else if (|pb_s6[41:37]) begin
			blue_w = 8'hff;
		end else begin
			blue_w = pb_s6[36:29];
		end
	end

	always_ff @(posedge clk) begin
		color.red   <= red_w;
		color.green <= green_w;
		color.blue  <= blue_w;
	end

endmodule

// ===== rtl/core/candle_flicker_pixel_generator_unit.sv =====
// Candle flame pixel generator: for each transfer of a pixel (frame number,
// column, row) it returns one RGB color of a flickering flame. One pixel is
// taken every clock cycle with no gaps; busy is always low. The result of a
// pixel is driven on color with done high for a single cycle only, in input
// order, and is taken at the seventh clock edge after the edge that took the
// pixel, so the receiver must take it then. The pipeline has seven register
// stages: phase, sine lookup, sine products, flicker and wind factors, shape
// products, channel products, clamp. Configuration writes take effect at once
// and must only be made while no pixel is in flight.
module candle_flicker_pixel_generator_unit
	import cfpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  pixel_t     pixel,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	output logic       done,
	output color_t     color
);

	cfg_t               cfg;
	logic               v_s1;
	s1_t                d_s1;
	logic               v_s2;
	logic signed [15:0] shape_s2;
	logic signed [15:0] sin_f, sin_r, sin_g;

	// the pipeline never stalls, so a pixel is always welcome
	assign busy = 1'b0;

	cfpg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1: three phase angles and the vertical shape
	cfpg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start && !busy),
		.pixel  (pixel),
		.v_s1   (v_s1),
		.d_s1   (d_s1)
	);

	// stage 2: one table lookup per angle
	cfpg_sine_lut u_sin_f (
		.clk   (clk),
		.angle (d_s1.ang_f),
		.sine  (sin_f)
	);

	cfpg_sine_lut u_sin_r (
		.clk   (clk),
		.angle (d_s1.ang_r),
		.sine  (sin_r)
	);

	cfpg_sine_lut u_sin_g (
		.clk   (clk),
		.angle (d_s1.ang_g),
		.sine  (sin_g)
	);

	// shape and valid ride alongside the lookups
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		shape_s2 <= d_s1.shape;
	end

	// stages 3 to 7: products, clamp and output register
	cfpg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s2     (v_s2),
		.shape_s2 (shape_s2),
		.sin_f    (sin_f),
		.sin_r    (sin_r),
		.sin_g    (sin_g),
		.cfg      (cfg),
		.done     (done),
		.color    (color)
	);

endmodule

// ===== rtl/core/cfpg_checker.sv =====
module cfpg_checker
	import cfpg_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input pixel_t pixel,
	input logic   done,
	input color_t color
);

	// every transfer in gives a result after the fixed latency
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LATENCY done)
		else $error("result missing after pixel transfer");

	// no result without a matching transfer in
	a_out_from_in: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("result without pixel transfer");

	// a row with a negative shape value, outside the flame, gives black
	a_dark_row: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && SHAPE_TAB[pixel.row][15] |-> ##PIPE_LATENCY
		(done && color == '0))
		else $error("row outside the flame not black");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind candle_flicker_pixel_generator_unit cfpg_checker u_cfpg_checker (.*);
